@@ src/ypco_pkg.sv @@
// ----------------------------------------------------------------------------
// ypco_pkg: shared constants for the yaw/pitch camera orientation block
// Field widths, command and register codes, reset pose and sine coefficients.
// ----------------------------------------------------------------------------
package ypco_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // transaction field widths
  localparam int KIND_W     = 3;
  localparam int AMOUNT_W   = 16;
  localparam int HEIGHT_W   = 32;
  localparam int POS_W      = 32;
  localparam int VEC_W      = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SPEED_W    = 16;
  localparam int ROT_STEP_W = 13;
  localparam int PLIMIT_W   = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 2'd2;

  localparam logic [SPEED_W-1:0]    SPEED_RST    = 16'd6554;
  localparam logic [ROT_STEP_W-1:0] ROT_STEP_RST = 13'd364;
  localparam logic [PLIMIT_W-1:0]   PLIMIT_RST   = 14'd16202;

  // command codes
  localparam logic [KIND_W-1:0] KIND_YAW     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PITCH   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FLY     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HEIGHT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd5;

  // initial pose, Q16.16
  localparam logic signed [POS_W-1:0] POS_X_RST = 32'sd0;
  localparam logic signed [POS_W-1:0] POS_Y_RST = 32'sd707789;
  localparam logic signed [POS_W-1:0] POS_Z_RST = 32'sd655360;

  // shared multiplier operand width
  localparam int MUL_W = 32;

  // quarter-wave sine polynomial, Q30
  localparam logic [30:0] POLY_A    = 31'd1686629713;
  localparam logic [30:0] POLY_B    = 31'd688904866;
  localparam logic [30:0] POLY_C    = 31'd76016977;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

endpackage

@@ src/ypco_in_if.sv @@
// ----------------------------------------------------------------------------
// ypco_in_if: command channel
// Valid/ready channel carrying one camera command per transaction.
// ----------------------------------------------------------------------------
interface ypco_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [ypco_pkg::KIND_W-1:0]     kind;
  logic signed [ypco_pkg::AMOUNT_W-1:0]   amount;
  logic signed [ypco_pkg::HEIGHT_W-1:0]   height_value;

  modport source (output valid, kind, amount, height_value, input ready);
  modport sink   (input valid, kind, amount, height_value, output ready);
endinterface

@@ src/ypco_out_if.sv @@
// ----------------------------------------------------------------------------
// ypco_out_if: pose channel
// Valid/ready channel carrying position, view direction and up vector.
// ----------------------------------------------------------------------------
interface ypco_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ypco_pkg::POS_W-1:0]   pos_x;
  logic signed [ypco_pkg::POS_W-1:0]   pos_y;
  logic signed [ypco_pkg::POS_W-1:0]   pos_z;
  logic signed [ypco_pkg::VEC_W-1:0]   dir_x;
  logic signed [ypco_pkg::VEC_W-1:0]   dir_y;
  logic signed [ypco_pkg::VEC_W-1:0]   dir_z;
  logic signed [ypco_pkg::VEC_W-1:0]   up_x;
  logic signed [ypco_pkg::VEC_W-1:0]   up_y;
  logic signed [ypco_pkg::VEC_W-1:0]   up_z;

  modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  up_x, up_y, up_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  up_x, up_y, up_z, output ready);
endinterface

@@ src/yaw_pitch_camera_orientation.sv @@
// ----------------------------------------------------------------------------
// yaw_pitch_camera_orientation: first-person camera pose unit
// Holds yaw, pitch and position; each command transaction updates the pose
// and returns position (Q16.16) plus view direction and up vector (Q1.14).
// One command is worked on at a time. The result is presented and
// in_if.ready rises on the same edge, once any earlier result has been
// taken; a result still waiting does not stop the next command from
// being accepted. Each command runs through the one shared 32x32
// multiplier: 4 sine evaluations of 5 steps each, 4 vector products, one
// command product and, for a move, two heading products. Configuration
// writes (cfg_we/cfg_index/cfg_data) take effect at once and must only be
// made while no command is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_orientation #(
  parameter int ANGLE_BITS     = ypco_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = ypco_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ypco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ypco_pkg::CFG_DATA_W-1:0]    cfg_data,
  ypco_in_if.sink                            in_if,
  ypco_out_if.source                         out_if
);

  localparam int MW       = ypco_pkg::MUL_W;
  localparam int PW       = ypco_pkg::POS_W;
  localparam int QB       = ANGLE_BITS - 2;        // bits inside a quarter turn
  localparam int TW       = TRIG_FRAC_BITS + 2;    // signed trig value width
  localparam int X_SH     = 30 - QB;               // folded angle to Q30
  localparam int X2_L     = (2 * QB <= 30) ? 30 - 2 * QB : 0;
  localparam int X2_R     = (2 * QB > 30) ? 2 * QB - 30 : 0;
  localparam int RND_SH   = 30 - TRIG_FRAC_BITS;
  localparam int MOVE_SH  = 8 + TRIG_FRAC_BITS;

  localparam logic [QB:0]           QUARTER     = {1'b1, {QB{1'b0}}};
  localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = {2'b01, {QB{1'b0}}};
  localparam logic [ANGLE_BITS-1:0] YAW_RST     = {2'b11, {QB{1'b0}}};

  // which sine/cosine the trig pass is producing
  localparam logic [1:0] TRIG_SIN_YAW   = 2'd0;
  localparam logic [1:0] TRIG_COS_YAW   = 2'd1;
  localparam logic [1:0] TRIG_SIN_PITCH = 2'd2;
  localparam logic [1:0] TRIG_COS_PITCH = 2'd3;

  localparam logic [2:0] TRIG_LAST = 3'd4;
  localparam logic [2:0] MOVE_LAST = 3'd2;
  localparam logic [2:0] PROD_LAST = 3'd4;

  // Sequencer:
  //   IDLE  wait for a command
  //   CMD   multiply amount by rotation step or move speed
  //   APPLY update angles / position from that product, or set height / restore
  //   TRIG  four sine evaluations, five multiplier steps each
  //   MOVE  heading products and saturating x/z update (move only)
  //   PROD  the four trig-by-trig products
  //   DONE  hand the result to the output register
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CMD   = 7'b0000010,
    S_APPLY = 7'b0000100,
    S_TRIG  = 7'b0001000,
    S_MOVE  = 7'b0010000,
    S_PROD  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;

  // configuration
  logic [ypco_pkg::SPEED_W-1:0]    speed_r;
  logic [ypco_pkg::ROT_STEP_W-1:0] rstep_r;
  logic [ypco_pkg::PLIMIT_W-1:0]   plimit_r;

  // pose
  logic        [ANGLE_BITS-1:0] yaw_r, yaw_nxt;
  logic signed [ANGLE_BITS-1:0] pitch_r, pitch_nxt;
  logic signed [PW-1:0]         posx_r, posx_nxt;
  logic signed [PW-1:0]         posy_r, posy_nxt;
  logic signed [PW-1:0]         posz_r, posz_nxt;

  // captured command
  logic        [ypco_pkg::KIND_W-1:0]   kind_r;
  logic signed [ypco_pkg::AMOUNT_W-1:0] amt_r;
  logic signed [ypco_pkg::HEIGHT_W-1:0] height_r;

  // working values
  logic signed [MW-1:0] scaled_r;
  logic        [30:0]   x2_r;
  logic signed [TW-1:0] sy_r, cy_r, sp_r, cp_r;
  logic [ypco_pkg::VEC_W-1:0] vdx_r, vdz_r, vux_r, vuz_r;

  // output register
  logic signed [PW-1:0]                opx_r, opy_r, opz_r;
  logic signed [ypco_pkg::VEC_W-1:0]   odx_r, ody_r, odz_r, oux_r, ouy_r, ouz_r;

  // shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod_r;
  logic        [2*MW-1:0] prod_u;

  ypco_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign prod_u = prod_r;

  // rounded shifts of the product (nearest, ties up)
  logic signed [2*MW-1:0] rs8, rs_move, rs_trig;
  assign rs8     = (prod_r + 64'sd128) >>> 8;
  assign rs_move = (prod_r + (64'sd1 <<< (MOVE_SH - 1))) >>> MOVE_SH;
  assign rs_trig = (prod_r + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;

  // --- sine datapath: fold the selected angle into the first quadrant ---
  logic [ANGLE_BITS-1:0] ang_base, ang;
  logic [1:0]            quad;
  logic [QB:0]           rfold;
  logic [30:0]           x_full, x2_c, hi30, p1, p2, s_cap;
  logic [31:0]           s_sum, s_mag;
  logic signed [TW-1:0]  sval;

  always_comb begin
    ang_base = idx_r[1] ? pitch_r : yaw_r;
    ang      = ang_base + (idx_r[0] ? ANG_QUARTER : '0);  // cosine as shifted sine
    quad     = ang[ANGLE_BITS-1 -: 2];
    rfold    = quad[0] ? (QUARTER - {1'b0, ang[QB-1:0]}) : {1'b0, ang[QB-1:0]};
    x_full   = 31'(rfold) << X_SH;
    x2_c     = 31'((prod_u << X2_L) >> X2_R);
    hi30     = prod_u[60:30];
    p1       = ypco_pkg::POLY_B - hi30;
    p2       = ypco_pkg::POLY_A - hi30;
    s_cap    = (hi30 > ypco_pkg::Q30_ONE) ? ypco_pkg::Q30_ONE : hi30;
    s_sum    = {1'b0, s_cap} + (32'd1 << (RND_SH - 1));
    s_mag    = s_sum >> RND_SH;
    sval     = TW'(quad[1] ? (32'd0 - s_mag) : s_mag);
  end

  // --- multiplier operand selection ---
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CMD: begin
        mul_a = MW'(amt_r);
        if (kind_r == ypco_pkg::KIND_YAW || kind_r == ypco_pkg::KIND_PITCH) begin
          mul_b = MW'(rstep_r);
        end else begin
          mul_b = MW'(speed_r);
        end
      end
      S_TRIG: begin
        case (step_r)
          3'd0: begin
            mul_a = MW'(rfold);
            mul_b = MW'(rfold);
          end
          3'd1: begin
            mul_a = MW'(x2_c);
            mul_b = MW'(ypco_pkg::POLY_C);
          end
          3'd2: begin
            mul_a = MW'(x2_r);
            mul_b = MW'(p1);
          end
          3'd3: begin
            mul_a = MW'(x_full);
            mul_b = MW'(p2);
          end
          default: ;
        endcase
      end
      S_MOVE: begin
        mul_a = scaled_r;
        mul_b = (step_r == 3'd0) ? MW'(cy_r) : MW'(sy_r);
      end
      S_PROD: begin
        case (step_r)
          3'd0: begin
            mul_a = MW'(cy_r);
            mul_b = MW'(cp_r);
          end
          3'd1: begin
            mul_a = MW'(sy_r);
            mul_b = MW'(cp_r);
          end
          3'd2: begin
            mul_a = -MW'(cy_r);   // up vector carries the minus sign
            mul_b = MW'(sp_r);
          end
          3'd3: begin
            mul_a = -MW'(sy_r);
            mul_b = MW'(sp_r);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // --- saturating position add ---
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                 input logic signed [63:0] delta);
    logic signed [63:0] sum;
    sum = 64'(base) + delta;
    if (sum > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (sum < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return sum[31:0];
  endfunction

  // pitch clamp; a limit past a quarter turn acts as a quarter turn
  logic signed [31:0] pitch_sum, lim, pitch_clamp;
  always_comb begin
    pitch_sum = 32'(pitch_r) + $signed(rs8[31:0]);
    lim       = (plimit_r > QUARTER) ? 32'(QUARTER) : 32'(plimit_r);
    if (pitch_sum < -lim) begin
      pitch_clamp = -lim;
    end else if (pitch_sum > lim) begin
      pitch_clamp = lim;
    end else begin
      pitch_clamp = pitch_sum;
    end
  end

  // --- sequencer and pose update ---
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    yaw_nxt       = yaw_r;
    pitch_nxt     = pitch_r;
    posx_nxt      = posx_r;
    posy_nxt      = posy_r;
    posz_nxt      = posz_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: state_nxt = S_APPLY;
      S_APPLY: begin
        case (kind_r)
          ypco_pkg::KIND_YAW:    yaw_nxt   = yaw_r + rs8[ANGLE_BITS-1:0];
          ypco_pkg::KIND_PITCH:  pitch_nxt = pitch_clamp[ANGLE_BITS-1:0];
          ypco_pkg::KIND_FLY:    posy_nxt  = sat_add(posy_r, rs8);
          ypco_pkg::KIND_HEIGHT: posy_nxt  = height_r;
          ypco_pkg::KIND_RESTORE: begin
            yaw_nxt   = YAW_RST;
            pitch_nxt = '0;
            posx_nxt  = ypco_pkg::POS_X_RST;
            posy_nxt  = ypco_pkg::POS_Y_RST;
            posz_nxt  = ypco_pkg::POS_Z_RST;
          end
          default: ;  // move keeps its product in scaled_r; spare kinds do nothing
        endcase
        state_nxt = S_TRIG;
        step_nxt  = '0;
        idx_nxt   = TRIG_SIN_YAW;
      end
      S_TRIG: begin
        if (step_r == TRIG_LAST) begin
          step_nxt = '0;
          if (idx_r == TRIG_COS_YAW && kind_r == ypco_pkg::KIND_MOVE) begin
            state_nxt = S_MOVE;
            idx_nxt   = TRIG_SIN_PITCH;
          end else if (idx_r == TRIG_COS_PITCH) begin
            state_nxt = S_PROD;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_MOVE: begin
        if (step_r == 3'd1) begin
          posx_nxt = sat_add(posx_r, rs_move);
        end
        if (step_r == MOVE_LAST) begin
          posz_nxt  = sat_add(posz_r, rs_move);
          state_nxt = S_TRIG;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_PROD: begin
        if (step_r == PROD_LAST) begin
          state_nxt = S_DONE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, configuration and pose registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      idx_r       <= TRIG_SIN_YAW;
      out_valid_r <= 1'b0;
      speed_r     <= ypco_pkg::SPEED_RST;
      rstep_r     <= ypco_pkg::ROT_STEP_RST;
      plimit_r    <= ypco_pkg::PLIMIT_RST;
      yaw_r       <= YAW_RST;
      pitch_r     <= '0;
      posx_r      <= ypco_pkg::POS_X_RST;
      posy_r      <= ypco_pkg::POS_Y_RST;
      posz_r      <= ypco_pkg::POS_Z_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      yaw_r       <= yaw_nxt;
      pitch_r     <= pitch_nxt;
      posx_r      <= posx_nxt;
      posy_r      <= posy_nxt;
      posz_r      <= posz_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ypco_pkg::CFG_MOVE_SPEED:  speed_r  <= cfg_data[ypco_pkg::SPEED_W-1:0];
          ypco_pkg::CFG_ROT_STEP:    rstep_r  <= cfg_data[ypco_pkg::ROT_STEP_W-1:0];
          ypco_pkg::CFG_PITCH_LIMIT: plimit_r <= cfg_data[ypco_pkg::PLIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      kind_r   <= in_if.kind;
      amt_r    <= in_if.amount;
      height_r <= in_if.height_value;
    end
    if (state_r == S_APPLY) begin
      scaled_r <= prod_r[MW-1:0];   // amount * move speed fits 32 bits
    end
    if (state_r == S_TRIG && step_r == 3'd1) begin
      x2_r <= x2_c;
    end
    if (state_r == S_TRIG && step_r == TRIG_LAST) begin
      case (idx_r)
        TRIG_SIN_YAW:   sy_r <= sval;
        TRIG_COS_YAW:   cy_r <= sval;
        TRIG_SIN_PITCH: sp_r <= sval;
        TRIG_COS_PITCH: cp_r <= sval;
        default: ;
      endcase
    end
    if (state_r == S_PROD) begin
      case (step_r)
        3'd1: vdx_r <= rs_trig[ypco_pkg::VEC_W-1:0];
        3'd2: vdz_r <= rs_trig[ypco_pkg::VEC_W-1:0];
        3'd3: vux_r <= rs_trig[ypco_pkg::VEC_W-1:0];
        3'd4: vuz_r <= rs_trig[ypco_pkg::VEC_W-1:0];
        default: ;
      endcase
    end
    if (state_r == S_DONE && (!out_valid_r || out_if.ready)) begin
      opx_r <= posx_r;
      opy_r <= posy_r;
      opz_r <= posz_r;
      odx_r <= vdx_r;
      ody_r <= ypco_pkg::VEC_W'(sp_r);
      odz_r <= vdz_r;
      oux_r <= vux_r;
      ouy_r <= ypco_pkg::VEC_W'(cp_r);
      ouz_r <= vuz_r;
    end
  end

  assign in_if.ready  = (state_r == S_IDLE);

  assign out_if.valid = out_valid_r;
  assign out_if.pos_x = opx_r;
  assign out_if.pos_y = opy_r;
  assign out_if.pos_z = opz_r;
  assign out_if.dir_x = odx_r;
  assign out_if.dir_y = ody_r;
  assign out_if.dir_z = odz_r;
  assign out_if.up_x  = oux_r;
  assign out_if.up_y  = ouy_r;
  assign out_if.up_z  = ouz_r;

endmodule

@@ src/ypco_mul.sv @@
// ----------------------------------------------------------------------------
// ypco_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module ypco_mul (
  input  logic                                 clk,
  input  logic signed [ypco_pkg::MUL_W-1:0]    op_a,
  input  logic signed [ypco_pkg::MUL_W-1:0]    op_b,
  output logic signed [2*ypco_pkg::MUL_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

@@ src/ypco_chk.sv @@
// ----------------------------------------------------------------------------
// ypco_chk: port-level checks for the camera orientation block
// Watches the command and pose channels; bound to the top level.
// ----------------------------------------------------------------------------
module ypco_chk #(
  parameter int TRIG_FRAC_BITS = ypco_pkg::TRIG_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ypco_in_if.sink     in_if,
  ypco_out_if.source  out_if
);

  // one command at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("command accepted while previous one in flight");

  // a stalled result holds
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.pos_x)
      && $stable(out_if.dir_x) && $stable(out_if.up_z))
    else $error("pending result dropped or changed");

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid && in_if.ready)
    else $error("block not idle after reset");

  // pitch is clamped within a quarter turn, so cos pitch is never negative
  a_up_y_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (TRIG_FRAC_BITS > 14) || !out_if.up_y[ypco_pkg::VEC_W-1])
    else $error("up_y negative");

endmodule

bind yaw_pitch_camera_orientation ypco_chk #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_ypco_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);
